// ----- rtl/core/csma_pkg.sv -----
// Shared codes for the CSMA-CA transmit access controller: commands, actions, phases, registers.
package csma_pkg;

  // Event codes on the input channel
  typedef enum logic [2:0] {
    CMD_START       = 3'd0,
    CMD_BACKOFF_END = 3'd1,
    CMD_TX_DONE     = 3'd2,
    CMD_ACK_SEEN    = 3'd3,
    CMD_ACK_TIMEOUT = 3'd4
  } cmd_t;

  // Action codes on the result channel
  typedef enum logic [2:0] {
    ACT_IGNORED   = 3'd0,
    ACT_BACKOFF   = 3'd1,
    ACT_TX_PLAIN  = 3'd2,
    ACT_TX_CCA    = 3'd3,
    ACT_ACK_TIMER = 3'd4,
    ACT_SUCCESS   = 3'd5,
    ACT_FAILURE   = 3'd6
  } action_t;

  // Frame phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_BACKOFF  = 2'd1,
    PH_TX_WAIT  = 2'd2,
    PH_ACK_WAIT = 2'd3
  } phase_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CSMA_ENABLE    = 3'd0,
    REG_ACK_ENABLE     = 3'd1,
    REG_MIN_EXPONENT   = 3'd2,
    REG_MAX_EXPONENT   = 3'd3,
    REG_MAX_TRIALS     = 3'd4,
    REG_UNIT_PERIOD    = 3'd5,
    REG_RETRY_LIMIT    = 3'd6,
    REG_ACK_WAIT_TICKS = 3'd7
  } reg_idx_t;

  // Backoff exponent ceiling
  localparam logic [3:0] EXP_CAP = 4'd8;

  // Bits of the random word taken through the remainder unit
  localparam int RND_W = 32;

endpackage

// ----- rtl/core/csma_ca_backoff_ack_retry.sv -----
// Top level of the unslotted CSMA-CA transmit access controller with ACK and retries.
//
// One event beat in gives exactly one action beat out. An event that needs no backoff
// draw is registered straight into the result. An event that draws a backoff delay
// runs S_DIV then S_MUL: the remainder of the 32-bit random word by (2^BE - 1) is
// formed by a bit-serial restoring remainder unit, one dividend bit per cycle,
// followed by the 8x16 multiply by the unit period. in_stall is high from accept
// until the result beat is taken. Configuration registers are read live at each event
// and must be written while idle.
module csma_ca_backoff_ack_retry (
  input  logic        clk,
  input  logic        rst_n,
  // event channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic        in_ack_wanted,
  input  logic        in_channel_clear,
  input  logic [31:0] in_random_value,
  // action channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [23:0] out_delay_ticks,
  output logic [3:0]  out_exponent_now,
  output logic [2:0]  out_retries_used,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_OUT
  } seq_t;

  // configuration registers
  logic        csma_enable_r;
  logic        ack_enable_r;
  logic [3:0]  min_exponent_r;
  logic [3:0]  max_exponent_r;
  logic [3:0]  max_trials_r;
  logic [15:0] unit_period_r;
  logic [2:0]  retry_limit_r;
  logic [15:0] ack_wait_ticks_r;

  // sequencer and frame state
  seq_t               seq_r;
  csma_pkg::phase_t   phase_r, phase_nxt;
  logic [3:0]         be_r, be_nxt;
  logic [3:0]         trial_r, trial_nxt;
  logic [2:0]         retry_r, retry_nxt;
  logic               ack_mode_r, ack_mode_nxt;
  csma_pkg::action_t  act_nxt;
  logic [23:0]        dly_nxt;
  logic               draw_nxt;

  // remainder unit
  logic [csma_pkg::RND_W-1:0] dvd_r;
  logic [7:0]                 rem_r;
  logic [7:0]                 mod_r;
  logic [4:0]                 cnt_r;
  logic [8:0]                 div_try;
  logic                       div_ge;
  logic [7:0]                 rem_step;

  // multiplier and delay floor
  logic [7:0]  rem_eff;
  logic [23:0] prod;
  logic [23:0] unit_ext;
  logic [23:0] delay_draw;

  // result register
  logic [2:0]  out_action_r;
  logic [23:0] out_delay_r;
  logic [3:0]  out_exponent_r;
  logic [2:0]  out_retries_r;

  logic in_beat;
  logic [3:0] min_cap;
  logic [3:0] max_cap;

  assign cfg_ready = 1'b1;
  assign in_stall  = (seq_r != S_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign out_valid = (seq_r == S_OUT);

  assign out_action       = out_action_r;
  assign out_delay_ticks  = out_delay_r;
  assign out_exponent_now = out_exponent_r;
  assign out_retries_used = out_retries_r;

  assign min_cap = (min_exponent_r > csma_pkg::EXP_CAP) ? csma_pkg::EXP_CAP : min_exponent_r;
  assign max_cap = (max_exponent_r > csma_pkg::EXP_CAP) ? csma_pkg::EXP_CAP : max_exponent_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csma_enable_r    <= 1'b1;
      ack_enable_r     <= 1'b1;
      min_exponent_r   <= 4'd3;
      max_exponent_r   <= 4'd5;
      max_trials_r     <= 4'd4;
      unit_period_r    <= 16'd20;
      retry_limit_r    <= 3'd3;
      ack_wait_ticks_r <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csma_pkg::REG_CSMA_ENABLE:    csma_enable_r    <= cfg_data[0];
        csma_pkg::REG_ACK_ENABLE:     ack_enable_r     <= cfg_data[0];
        csma_pkg::REG_MIN_EXPONENT:   min_exponent_r   <= cfg_data[3:0];
        csma_pkg::REG_MAX_EXPONENT:   max_exponent_r   <= cfg_data[3:0];
        csma_pkg::REG_MAX_TRIALS:     max_trials_r     <= cfg_data[3:0];
        csma_pkg::REG_UNIT_PERIOD:    unit_period_r    <= cfg_data;
        csma_pkg::REG_RETRY_LIMIT:    retry_limit_r    <= cfg_data[2:0];
        csma_pkg::REG_ACK_WAIT_TICKS: ack_wait_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Event decode: next frame state, action, and whether a delay must be drawn
  always_comb begin
    logic attempt;
    logic fail;
    phase_nxt    = phase_r;
    be_nxt       = be_r;
    trial_nxt    = trial_r;
    retry_nxt    = retry_r;
    ack_mode_nxt = ack_mode_r;
    act_nxt      = csma_pkg::ACT_IGNORED;
    dly_nxt      = '0;
    draw_nxt     = 1'b0;
    attempt      = 1'b0;
    fail         = 1'b0;

    case (in_command)
      csma_pkg::CMD_START: begin
        if (phase_r == csma_pkg::PH_IDLE) begin
          ack_mode_nxt = ack_enable_r & in_ack_wanted;
          retry_nxt    = '0;
          attempt      = 1'b1;
        end
      end
      csma_pkg::CMD_BACKOFF_END: begin
        if (phase_r == csma_pkg::PH_BACKOFF) begin
          if (in_channel_clear) begin
            phase_nxt = csma_pkg::PH_TX_WAIT;
            act_nxt   = csma_pkg::ACT_TX_CCA;
          end else begin
            trial_nxt = trial_r + 4'd1;
            if (be_r < max_cap) be_nxt = be_r + 4'd1;
            if (trial_nxt >= max_trials_r) begin
              fail = 1'b1;
            end else begin
              draw_nxt = 1'b1;
              act_nxt  = csma_pkg::ACT_BACKOFF;
            end
          end
        end
      end
      csma_pkg::CMD_TX_DONE: begin
        if (phase_r == csma_pkg::PH_TX_WAIT) begin
          if (ack_mode_r) begin
            phase_nxt = csma_pkg::PH_ACK_WAIT;
            dly_nxt   = {8'd0, ack_wait_ticks_r};
            act_nxt   = csma_pkg::ACT_ACK_TIMER;
          end else begin
            phase_nxt = csma_pkg::PH_IDLE;
            act_nxt   = csma_pkg::ACT_SUCCESS;
          end
        end
      end
      csma_pkg::CMD_ACK_SEEN: begin
        if (phase_r == csma_pkg::PH_ACK_WAIT) begin
          phase_nxt = csma_pkg::PH_IDLE;
          act_nxt   = csma_pkg::ACT_SUCCESS;
        end
      end
      csma_pkg::CMD_ACK_TIMEOUT: begin
        if (phase_r == csma_pkg::PH_ACK_WAIT) fail = 1'b1;
      end
      default: ;
    endcase

    // failed attempt: retry if allowed, else give up
    if (fail) begin
      if (ack_mode_nxt && (retry_nxt < retry_limit_r)) begin
        retry_nxt = retry_nxt + 3'd1;
        attempt   = 1'b1;
      end else begin
        phase_nxt = csma_pkg::PH_IDLE;
        act_nxt   = csma_pkg::ACT_FAILURE;
      end
    end

    // new attempt; with no trials allowed every retry fails at once
    if (attempt) begin
      trial_nxt = '0;
      if (csma_enable_r) begin
        be_nxt = min_cap;
        if (max_trials_r == 4'd0) begin
          if (ack_mode_nxt && (retry_nxt < retry_limit_r)) retry_nxt = retry_limit_r;
          phase_nxt = csma_pkg::PH_IDLE;
          act_nxt   = csma_pkg::ACT_FAILURE;
        end else begin
          phase_nxt = csma_pkg::PH_BACKOFF;
          draw_nxt  = 1'b1;
          act_nxt   = csma_pkg::ACT_BACKOFF;
        end
      end else begin
        be_nxt    = '0;
        phase_nxt = csma_pkg::PH_TX_WAIT;
        act_nxt   = csma_pkg::ACT_TX_PLAIN;
      end
    end
  end

  // Restoring remainder step, one dividend bit per cycle
  assign div_try  = {rem_r, dvd_r[csma_pkg::RND_W-1]};
  assign div_ge   = (div_try >= {1'b0, mod_r});
  assign rem_step = div_ge ? 8'(div_try - {1'b0, mod_r}) : div_try[7:0];

  // Delay = remainder * unit, floored at one unit; modulus zero gives remainder zero
  assign rem_eff    = (mod_r == 8'd0) ? 8'd0 : rem_r;
  assign unit_ext   = {8'd0, unit_period_r};
  assign prod       = {16'd0, rem_eff} * unit_ext;
  assign delay_draw = (prod < unit_ext) ? unit_ext : prod;

  // Sequencer, frame state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r      <= S_IDLE;
      phase_r    <= csma_pkg::PH_IDLE;
      be_r       <= '0;
      trial_r    <= '0;
      retry_r    <= '0;
      ack_mode_r <= 1'b0;
    end else begin
      case (seq_r)
        S_IDLE: begin
          if (in_beat) begin
            phase_r        <= phase_nxt;
            be_r           <= be_nxt;
            trial_r        <= trial_nxt;
            retry_r        <= retry_nxt;
            ack_mode_r     <= ack_mode_nxt;
            out_action_r   <= act_nxt;
            out_delay_r    <= dly_nxt;
            out_exponent_r <= be_nxt;
            out_retries_r  <= retry_nxt;
            dvd_r          <= in_random_value;
            rem_r          <= '0;
            cnt_r          <= '0;
            mod_r          <= 8'((9'd1 << be_nxt) - 9'd1);
            seq_r          <= draw_nxt ? S_DIV : S_OUT;
          end
        end
        S_DIV: begin
          rem_r <= rem_step;
          dvd_r <= {dvd_r[csma_pkg::RND_W-2:0], 1'b0};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(csma_pkg::RND_W - 1)) seq_r <= S_MUL;
        end
        S_MUL: begin
          out_delay_r <= delay_draw;
          seq_r       <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) seq_r <= S_IDLE;
        end
        default: seq_r <= S_IDLE;
      endcase
    end
  end

endmodule
